FILE: rtl/scst_pkg.sv
`timescale 1ns / 1ps
package scst_pkg;

	// Default sizes
	localparam int DEPTH_DEF      = 256;
	localparam int MAX_LEVELS_DEF = 16;
	localparam int KEY_WIDTH_DEF  = 64;

	// Command codes
	localparam logic [1:0] FUNC_REGISTER = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP   = 2'd1;
	localparam logic [1:0] FUNC_LEVEL_UP = 2'd2;
	localparam logic [1:0] FUNC_LEVEL_DN = 2'd3;

	// Status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_TABLE_FULL = 2'd1;
	localparam logic [1:0] STAT_LEVEL_LIM  = 2'd2;
	localparam logic [1:0] STAT_LEVEL_ZERO = 2'd3;

	// Configuration registers
	localparam int         CAP_WIDTH     = 9;
	localparam logic [8:0] CAP_RESET     = 9'd256;
	localparam logic       REG_CAPACITY  = 1'b0;
	localparam int         PADDR_WIDTH   = 3;

endpackage

FILE: rtl/scst_ram.sv
`timescale 1ns / 1ps
module scst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/scoped_symbol_table_unit.sv
`timescale 1ns / 1ps
// Scope-stacked symbol table.
// Input channel (in_valid/in_ready) carries func, name_key and type_code;
// output channel (out_valid/out_ready) carries status, entry_index and
// found_type, exactly one result per input transfer, in order.
// Register, level up and failed commands go from the input transfer straight
// to the result state; level down first reads one scope mark from its RAM.
// Lookup scans the entry RAM from the newest entry down, one entry per cycle
// through the registered read port, and stops at the first hit or once
// entry 0 has been compared.
// The block works on one item at a time; in_ready is high only when idle.
// A finished result waits in a holding register while the output register
// is still occupied, so a stalled receiver delays the next item's start by
// at most one result, and no result is dropped.
// Reset (arst_n low) empties the table, returns to scope level zero and sets
// capacity to 256; no clearing pass is needed.
// The APB port holds one register, capacity, at byte address 0.
module scoped_symbol_table_unit #(
	parameter int DEPTH      = scst_pkg::DEPTH_DEF,
	parameter int MAX_LEVELS = scst_pkg::MAX_LEVELS_DEF,
	parameter int KEY_WIDTH  = scst_pkg::KEY_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       func,
	input  logic [63:0]                      name_key,
	input  logic [7:0]                       type_code,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic [7:0]                       entry_index,
	output logic [7:0]                       found_type,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [scst_pkg::PADDR_WIDTH-1:0] paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int LW  = $clog2(MAX_LEVELS);
	localparam int WW  = ((CW > scst_pkg::CAP_WIDTH) ? CW : scst_pkg::CAP_WIDTH) + 1;
	localparam int EW  = KEY_WIDTH + 8;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_MARK = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	logic [1:0]                     state_q;
	logic [CW-1:0]                  count_q;
	logic [LW-1:0]                  level_q;
	logic [scst_pkg::CAP_WIDTH-1:0] cap_q;
	logic [AW-1:0]                  scan_q;
	logic [AW-1:0]                  cmp_idx_q;
	logic                           pend_q;
	logic [KEY_WIDTH-1:0]           key_q;
	logic [1:0]                     res_status_q;
	logic [7:0]                     res_index_q;
	logic [7:0]                     res_type_q;
	logic                           out_valid_q;
	logic [1:0]                     out_status_q;
	logic [7:0]                     out_index_q;
	logic [7:0]                     out_type_q;

	logic                 accept;
	logic                 cfg_wr;
	logic                 full;
	logic                 at_top;
	logic [CW+7:0]        count_ext;
	logic                 key_we;
	logic [EW-1:0]        key_rdata;
	logic                 key_re;
	logic                 mark_we;
	logic                 mark_re;
	logic [LW-1:0]        mark_waddr;
	logic [CW-1:0]        mark_rdata;
	logic                 hit;
	logic                 out_free;

	// Handshakes and configuration port
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready
		&& (paddr[2] == scst_pkg::REG_CAPACITY);
	assign prdata    = (paddr[2] == scst_pkg::REG_CAPACITY)
		? {{(32 - scst_pkg::CAP_WIDTH){1'b0}}, cap_q} : 32'd0;

	// Table state checks
	assign full      = (WW'(count_q) >= WW'(cap_q)) || (count_q >= CW'(DEPTH));
	assign at_top    = (level_q == LW'(MAX_LEVELS - 1));
	assign count_ext = {8'd0, count_q};
	assign hit       = pend_q && (key_rdata[KEY_WIDTH-1:0] == key_q);

	// Entry RAM: write on register, read while scanning
	assign key_we = accept && (func == scst_pkg::FUNC_REGISTER) && !full;
	assign key_re = (state_q == ST_SCAN);

	scst_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(count_q[AW-1:0]),
		.wdata({type_code, name_key[KEY_WIDTH-1:0]}),
		.re   (key_re),
		.raddr(scan_q),
		.rdata(key_rdata)
	);

	// Scope mark RAM: write on level up, read on level down
	assign mark_we    = accept && (func == scst_pkg::FUNC_LEVEL_UP) && !at_top;
	assign mark_re    = accept && (func == scst_pkg::FUNC_LEVEL_DN);
	assign mark_waddr = level_q + 1'b1;

	scst_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_LEVELS)
	) u_mark_ram (
		.clk  (clk),
		.we   (mark_we),
		.waddr(mark_waddr),
		.wdata(count_q),
		.re   (mark_re),
		.raddr(level_q),
		.rdata(mark_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			level_q      <= '0;
			cap_q        <= scst_pkg::CAP_RESET;
			scan_q       <= '0;
			cmp_idx_q    <= '0;
			pend_q       <= 1'b0;
			key_q        <= '0;
			res_status_q <= scst_pkg::STAT_OK;
			res_index_q  <= '0;
			res_type_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= scst_pkg::STAT_OK;
			out_index_q  <= '0;
			out_type_q   <= '0;
		end else begin
			if (cfg_wr) begin
				cap_q <= pwdata[scst_pkg::CAP_WIDTH-1:0];
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						res_status_q <= scst_pkg::STAT_OK;
						res_index_q  <= '0;
						res_type_q   <= '0;
						state_q      <= ST_RESP;
						unique case (func)
							scst_pkg::FUNC_REGISTER: begin
								if (full) begin
									res_status_q <= scst_pkg::STAT_TABLE_FULL;
								end else begin
									res_index_q <= count_ext[7:0];
									count_q     <= count_q + 1'b1;
								end
							end
							scst_pkg::FUNC_LOOKUP: begin
								key_q  <= name_key[KEY_WIDTH-1:0];
								scan_q <= AW'(count_q - 1'b1);
								pend_q <= 1'b0;
								if (count_q != '0) begin
									state_q <= ST_SCAN;
								end
							end
							scst_pkg::FUNC_LEVEL_UP: begin
								if (at_top) begin
									res_status_q <= scst_pkg::STAT_LEVEL_LIM;
								end else begin
									level_q <= level_q + 1'b1;
								end
							end
							scst_pkg::FUNC_LEVEL_DN: begin
								if (level_q == '0) begin
									res_status_q <= scst_pkg::STAT_LEVEL_ZERO;
								end else begin
									state_q <= ST_MARK;
								end
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				// One read issued per cycle, the previous one compared
				ST_SCAN: begin
					if (hit) begin
						res_type_q <= key_rdata[EW-1:KEY_WIDTH];
						state_q    <= ST_RESP;
					end else if (pend_q && (cmp_idx_q == '0)) begin
						state_q <= ST_RESP;
					end else begin
						pend_q    <= 1'b1;
						cmp_idx_q <= scan_q;
						if (scan_q != '0) begin
							scan_q <= scan_q - 1'b1;
						end
					end
				end
				// Truncate back to the mark of the scope being left
				ST_MARK: begin
					count_q <= mark_rdata;
					level_q <= level_q - 1'b1;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_index_q  <= res_index_q;
						out_type_q   <= res_type_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_index = out_index_q;
	assign found_type  = out_type_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_reg_incr: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |=> (count_q == $past(count_q) + 1'b1))
		else $error("register did not advance the count");

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RESP))
		else $error("result shown without a finished command");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CW'(scan_q) < count_q))
		else $error("scan address beyond the table");

	a_level_down: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |=> (level_q == $past(level_q) - 1'b1))
		else $error("level down did not drop the level");

endmodule

FILE: tb/scoped_symbol_table_unit_tb.sv
`timescale 1ns / 1ps
module scoped_symbol_table_unit_tb;
	import scst_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam logic [PADDR_WIDTH-1:0] CAPACITY_ADDR = PADDR_WIDTH'(4 * REG_CAPACITY);

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] entry_index;
		logic [7:0] found_type;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] func;
	logic [63:0] name_key;
	logic [7:0] type_code;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic [7:0] entry_index;
	logic [7:0] found_type;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_WIDTH-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// Shadow copy of the table
	logic [63:0] sym_keys [DEPTH_DEF];
	logic [7:0] sym_types [DEPTH_DEF];
	int sym_count;
	int sym_level;
	int sym_marks [MAX_LEVELS_DEF];
	int sym_capacity;

	answer_t expected_answers [$];
	logic [63:0] key_pool [12];
	int error_count = 0;
	int cycle_count = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_len = 0;

	scoped_symbol_table_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.name_key    (name_key),
		.type_code   (type_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.entry_index (entry_index),
		.found_type  (found_type),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #5 clk = ~clk;

	// Table behavior: updates the shadow state and returns the answer
	function automatic answer_t predict_answer(input logic [1:0] f, input logic [63:0] k,
			input logic [7:0] t);
		answer_t a;
		int lim;
		int i;
		bit hit;
		a = '0;
		a.status = STAT_OK;
		lim = (sym_capacity > DEPTH_DEF) ? DEPTH_DEF : sym_capacity;
		hit = 1'b0;
		case (f)
			FUNC_REGISTER: begin
				if (sym_count >= lim) begin
					a.status = STAT_TABLE_FULL;
				end else begin
					sym_keys[sym_count] = k;
					sym_types[sym_count] = t;
					a.entry_index = 8'(sym_count);
					sym_count++;
				end
			end
			FUNC_LOOKUP: begin
				// newest entry wins
				for (i = sym_count - 1; i >= 0 && !hit; i--) begin
					if (sym_keys[i] == k) begin
						a.found_type = sym_types[i];
						hit = 1'b1;
					end
				end
			end
			FUNC_LEVEL_UP: begin
				if (sym_level >= MAX_LEVELS_DEF - 1) begin
					a.status = STAT_LEVEL_LIM;
				end else begin
					sym_level++;
					sym_marks[sym_level] = sym_count;
				end
			end
			default: begin
				if (sym_level == 0) begin
					a.status = STAT_LEVEL_ZERO;
				end else begin
					sym_count = sym_marks[sym_level];
					sym_level--;
				end
			end
		endcase
		return a;
	endfunction

	// One input transfer; entered and left just after a falling edge
	task automatic send_item(input logic [1:0] f, input logic [63:0] k, input logic [7:0] t);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		name_key <= k;
		type_code <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_answers.push_back(predict_answer(f, k, t));
		@(negedge clk);
	endtask

	// Wait until every pending answer is back
	task automatic drain_answers();
		in_valid <= 1'b0;
		while (expected_answers.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [8:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= {23'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sym_capacity = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [63:0] pick_key();
		if ($urandom_range(99) < 80)
			return key_pool[$urandom_range(11)];
		return {$urandom, $urandom};
	endfunction

	task automatic run_mixed_traffic(input int n, input int reg_pct, input int look_pct,
			input int up_pct);
		int i;
		int r;
		logic [1:0] f;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < reg_pct)
				f = FUNC_REGISTER;
			else if (r < reg_pct + look_pct)
				f = FUNC_LOOKUP;
			else if (r < reg_pct + look_pct + up_pct)
				f = FUNC_LEVEL_UP;
			else
				f = FUNC_LEVEL_DN;
			send_item(f, pick_key(), 8'($urandom));
		end
	endtask

	// Key extremes, shadowing across a scope, truncation on level down
	task automatic test_basic_scopes();
		send_item(FUNC_LOOKUP, 64'd0, 8'hff);
		send_item(FUNC_LEVEL_DN, 64'd0, 8'd0);
		send_item(FUNC_REGISTER, 64'd0, 8'd0);
		send_item(FUNC_REGISTER, '1, 8'hff);
		send_item(FUNC_REGISTER, key_pool[2], 8'h5a);
		send_item(FUNC_LOOKUP, '1, 8'd0);
		send_item(FUNC_LOOKUP, key_pool[2], 8'h33);
		send_item(FUNC_LEVEL_UP, key_pool[3], 8'h11);
		send_item(FUNC_REGISTER, 64'd0, 8'ha5);
		send_item(FUNC_LOOKUP, 64'd0, 8'd0);
		send_item(FUNC_LOOKUP, {$urandom, $urandom}, 8'd0);
		send_item(FUNC_LEVEL_DN, 64'd0, 8'd0);
		send_item(FUNC_LOOKUP, 64'd0, 8'd0);
		send_item(FUNC_LEVEL_DN, 64'd0, 8'd0);
		drain_answers();
	endtask

	// Capacity below the count, capacity zero, and a small limit
	task automatic test_capacity_limits();
		write_capacity(9'd1);
		send_item(FUNC_REGISTER, key_pool[4], 8'h21);
		send_item(FUNC_LOOKUP, key_pool[2], 8'd0);
		drain_answers();
		write_capacity(9'd0);
		send_item(FUNC_REGISTER, key_pool[4], 8'h22);
		send_item(FUNC_LOOKUP, '1, 8'd0);
		drain_answers();
		write_capacity(9'd4);
		send_item(FUNC_REGISTER, key_pool[4], 8'h23);
		send_item(FUNC_REGISTER, key_pool[5], 8'h24);
		send_item(FUNC_LOOKUP, key_pool[4], 8'd0);
		drain_answers();
	endtask

	// Fill every slot, then overflow and long lookups
	task automatic test_fill_table();
		int i;
		write_capacity(9'd511);
		src_idle_pct = 31;
		sink_stall_pct = 31;
		while (sym_count < DEPTH_DEF)
			send_item(FUNC_REGISTER, pick_key(), 8'($urandom));
		send_item(FUNC_REGISTER, pick_key(), 8'($urandom));
		send_item(FUNC_REGISTER, pick_key(), 8'($urandom));
		for (i = 0; i < 6; i++)
			send_item(FUNC_LOOKUP, pick_key(), 8'($urandom));
		send_item(FUNC_LEVEL_UP, pick_key(), 8'($urandom));
		send_item(FUNC_LEVEL_DN, pick_key(), 8'($urandom));
		drain_answers();
	endtask

	// Capacity set under the current count
	task automatic test_lowered_capacity();
		write_capacity(9'($urandom_range(1, 255)));
		src_idle_pct = 76;
		sink_stall_pct = 0;
		run_mixed_traffic(210, 40, 35, 12);
		drain_answers();
	endtask

	// Mostly level up, so the last mark slot is reached
	task automatic test_scope_depth();
		write_capacity(9'd511);
		src_idle_pct = 0;
		sink_stall_pct = 76;
		run_mixed_traffic(210, 25, 20, 45);
		drain_answers();
	endtask

	task automatic test_single_slot();
		write_capacity(9'd1);
		src_idle_pct = 31;
		sink_stall_pct = 31;
		run_mixed_traffic(150, 40, 30, 15);
		drain_answers();
	endtask

	// Receiver holds off while the sender keeps offering transfers
	task automatic test_output_backpressure();
		int i;
		write_capacity(9'd511);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_len = 300;
		hold_req = 1'b1;
		for (i = 0; i < 20; i++)
			send_item((i % 3 == 0) ? FUNC_LOOKUP : FUNC_REGISTER, pick_key(), 8'($urandom));
		drain_answers();
	endtask

	task automatic test_mixed_random(input logic [8:0] cap, input int src_pct,
			input int sink_pct, input int n);
		write_capacity(cap);
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		run_mixed_traffic(n, 40, 35, 12);
		drain_answers();
	endtask

	// Receiver side
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result status %0d index %0d type %0d",
					$time, status, entry_index, found_type);
				error_count++;
			end else begin
				want = expected_answers.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, status);
					error_count++;
				end
				if (entry_index !== want.entry_index) begin
					$display("%0t: entry_index expected %0d actual %0d",
						$time, want.entry_index, entry_index);
					error_count++;
				end
				if (found_type !== want.found_type) begin
					$display("%0t: found_type expected %0d actual %0d",
						$time, want.found_type, found_type);
					error_count++;
				end
			end
		end
	end

	// Run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_REGISTER;
		name_key = '0;
		type_code = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sym_count = 0;
		sym_level = 0;
		sym_marks[0] = 0;
		sym_capacity = CAP_RESET;
		key_pool[0] = 64'd0;
		key_pool[1] = '1;
		for (i = 2; i < 12; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_scopes();
		test_capacity_limits();
		test_mixed_random(9'd511, 0, 0, 210);
		test_fill_table();
		test_lowered_capacity();
		test_scope_depth();
		test_single_slot();
		test_output_backpressure();
		test_mixed_random(9'd256, 31, 31, 210);

		repeat (8) @(posedge clk);
		error_count += expected_answers.size();
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
